// ----- rtl/predicate_logic_lexer_top_defines.svh -----
// ----------------------------------------------------------------------------
// Predicate logic lexer assertion macros
// Helpers for concurrent checks in the lexer controller.
// ----------------------------------------------------------------------------
`ifndef PREDICATE_LOGIC_LEXER_TOP_DEFINES_SVH
`define PREDICATE_LOGIC_LEXER_TOP_DEFINES_SVH

// same-cycle implication
`define PLX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("plx assertion failed");

// next-cycle implication
`define PLX_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("plx assertion failed");

`endif

// ----- rtl/plx_pkg.sv -----
// ----------------------------------------------------------------------------
// Lexer package
// Token kinds, character codes, keyword tables and the controller interface.
// ----------------------------------------------------------------------------
package plx_pkg;

    localparam int POSITION_BITS_DEF = 24;
    localparam int LINE_BITS_DEF     = 24;
    localparam int KIND_W            = 6;
    localparam int NUM_KW            = 8;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind K_UNKNOWN   = 6'd0;
    localparam t_kind K_NEWLINE   = 6'd1;
    localparam t_kind K_THEREFORE = 6'd2;
    localparam t_kind K_QUERY     = 6'd3;
    localparam t_kind K_BICOND    = 6'd4;
    localparam t_kind K_IMPL      = 6'd5;
    localparam t_kind K_OR        = 6'd6;
    localparam t_kind K_AND       = 6'd7;
    localparam t_kind K_NEG       = 6'd8;
    localparam t_kind K_LPAR      = 6'd9;
    localparam t_kind K_RPAR      = 6'd10;
    localparam t_kind K_COMMA     = 6'd11;
    localparam t_kind K_SEMI      = 6'd12;
    localparam t_kind K_FORALL    = 6'd13;
    localparam t_kind K_LUNIV     = 6'd14;
    localparam t_kind K_RUNIV     = 6'd15;
    localparam t_kind K_FORSOME   = 6'd16;
    localparam t_kind K_LEXIST    = 6'd17;
    localparam t_kind K_REXIST    = 6'd18;
    localparam t_kind K_LBRACE    = 6'd19;
    localparam t_kind K_RBRACE    = 6'd20;
    localparam t_kind K_EQUAL     = 6'd21;
    localparam t_kind K_NOTEQ     = 6'd22;
    localparam t_kind K_ARGUMENT  = 6'd23;
    localparam t_kind K_QUIT      = 6'd24;
    localparam t_kind K_TRUE      = 6'd25;
    localparam t_kind K_FALSE     = 6'd26;
    localparam t_kind K_SOS       = 6'd27;
    localparam t_kind K_OPTIONS   = 6'd28;
    localparam t_kind K_NUMBER    = 6'd29;
    localparam t_kind K_NEGNUM    = 6'd30;
    localparam t_kind K_STRING    = 6'd31;
    localparam t_kind K_IDENT     = 6'd32;
    localparam t_kind K_PIDENT    = 6'd33;
    localparam t_kind K_END       = 6'd34;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QUES   = 8'h3F;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    // keywords: quit true false argument forall forsome sos options
    localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
        '{"q", "u", "i", "t", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
        '{"a", "r", "g", "u", "m", "e", "n", "t"},
        '{"f", "o", "r", "a", "l", "l", 8'h00, 8'h00},
        '{"f", "o", "r", "s", "o", "m", "e", 8'h00},
        '{"s", "o", "s", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"o", "p", "t", "i", "o", "n", "s", 8'h00}
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd4, 4'd4, 4'd5, 4'd8, 4'd6, 4'd7, 4'd3, 4'd7};
    localparam t_kind KW_KIND [NUM_KW] = '{K_QUIT, K_TRUE, K_FALSE, K_ARGUMENT,
                                           K_FORALL, K_FORSOME, K_SOS, K_OPTIONS};

    typedef struct packed {
        logic load;
        logic step;
        logic push_last;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic item_done;
        logic hold_valid;
        logic out_valid;
    } t_stat;

    function automatic logic [NUM_KW-1:0] kw_first_mask(input logic [7:0] lc);
        logic [NUM_KW-1:0] m;
        m = '0;
        for (int k = 0; k < NUM_KW; k++) begin
            m[k] = (KW_TEXT[k][0] == lc);
        end
        return m;
    endfunction

endpackage

// ----- rtl/plx_byte_if.sv -----
// ----------------------------------------------------------------------------
// Lexer input channel
// One text byte or an end-of-text mark per item.
// ----------------------------------------------------------------------------
interface plx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ----- rtl/plx_tok_if.sv -----
// ----------------------------------------------------------------------------
// Lexer token channel
// One token per item with kind, offsets, line and end-of-run flag.
// ----------------------------------------------------------------------------
interface plx_tok_if
    import plx_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int LINE_BITS     = LINE_BITS_DEF
);
    logic                     valid;
    logic                     ready;
    t_kind                    token_kind;
    logic [POSITION_BITS-1:0] token_start;
    logic [POSITION_BITS-1:0] token_end;
    logic [LINE_BITS-1:0]     line_number;
    logic                     last_of_run;

    modport source (output valid, output token_kind, output token_start, output token_end,
                    output line_number, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input token_start, input token_end,
                    input line_number, input last_of_run, output ready);
endinterface

// ----- rtl/plx_ctrl.sv -----
// ----------------------------------------------------------------------------
// Lexer controller
// Sequences item intake, scan steps and release of the final token.
// ----------------------------------------------------------------------------
`include "predicate_logic_lexer_top_defines.svh"

module plx_ctrl
    import plx_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_WAIT  = 3'b001,
        ST_STEP  = 3'b010,
        ST_FLUSH = 3'b100
    } t_ctl_state;

    t_ctl_state r_state, n_state;
    logic       out_free;

    assign out_free   = !i_stat.out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_WAIT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_WAIT: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_STEP;
                end
            end
            ST_STEP: begin
                // a new token displaces the held one only into a free output slot
                if (!i_stat.emit || !i_stat.hold_valid || out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_stat.item_done) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!i_stat.hold_valid) begin
                    n_state = ST_WAIT;
                end else if (out_free) begin
                    o_cmd.push_last = 1'b1;
                    n_state         = ST_WAIT;
                end
            end
            default: begin
                n_state = ST_WAIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_WAIT;
        end else begin
            r_state <= n_state;
        end
    end

    `PLX_ASSERT_IMP(a_push_free, i_clk, i_rst_n, o_cmd.push_last, out_free)
    `PLX_ASSERT_IMP(a_move_free, i_clk, i_rst_n, o_cmd.step && i_stat.emit && i_stat.hold_valid, out_free)
    `PLX_ASSERT_NXT(a_accept_step, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == ST_STEP)

endmodule

// ----- rtl/plx_dpath.sv -----
// ----------------------------------------------------------------------------
// Lexer datapath
// Scan state, position and line counters, dash replay and token staging.
// ----------------------------------------------------------------------------
module plx_dpath
    import plx_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int LINE_BITS     = LINE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic                     i_cfg_wr_data,
    input  logic [7:0]               i_text_byte,
    input  logic                     i_end_of_text,
    input  logic                     i_out_ready,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    output logic                     o_out_valid,
    output logic [KIND_W-1:0]        o_token_kind,
    output logic [POSITION_BITS-1:0] o_token_start,
    output logic [POSITION_BITS-1:0] o_token_end,
    output logic [LINE_BITS-1:0]     o_line_number,
    output logic                     o_last_of_run
);

    typedef logic [POSITION_BITS-1:0] t_pos;
    typedef logic [LINE_BITS-1:0]     t_line;

    typedef enum logic [17:0] {
        M_IDLE    = 18'h00001,
        M_BAR     = 18'h00002,
        M_QUES    = 18'h00004,
        M_BANG    = 18'h00008,
        M_LT      = 18'h00010,
        M_LT1     = 18'h00020,
        M_LT2     = 18'h00040,
        M_MINUS   = 18'h00080,
        M_MINUS2  = 18'h00100,
        M_AMP     = 18'h00200,
        M_WORD_LO = 18'h00400,
        M_WORD_UP = 18'h00800,
        M_IDENT   = 18'h01000,
        M_PIDENT  = 18'h02000,
        M_NUMBER  = 18'h04000,
        M_NEGNUM  = 18'h08000,
        M_STRING  = 18'h10000,
        M_COMMENT = 18'h20000
    } t_mode;

    logic              r_skip;
    t_mode             r_mode, n_mode;
    logic [NUM_KW-1:0] r_cand, n_cand;
    logic [3:0]        r_mlen, n_mlen;
    t_pos              r_cur_pos, r_pend_start, r_rep_pos, r_pos;
    t_line             r_line, r_pend_line;
    logic [1:0]        r_rep_cnt, set_rep;
    logic [7:0]        r_byte;
    logic              r_eot;

    logic              r_hold_valid;
    t_kind             r_hold_kind;
    t_pos              r_hold_start, r_hold_end;
    t_line             r_hold_line;
    logic              r_out_valid, r_out_last;
    t_kind             r_out_kind;
    t_pos              r_out_start, r_out_end;
    t_line             r_out_line;

    logic              rep, eot, done, beg, line_inc, restart;
    logic [7:0]        c, lc;
    t_pos              p, eb;
    logic              is_up, is_lo, is_dig, is_aln;
    logic              e;
    t_kind             ek;
    t_pos              es, ee;
    t_line             el;
    logic [NUM_KW-1:0] wmask, fmask;
    logic              whit;
    t_kind             wkind;

    assign rep    = (r_rep_cnt != 2'd0);
    assign c      = rep ? CH_DASH : r_byte;
    assign p      = rep ? r_rep_pos : r_pos;
    assign eot    = !rep && r_eot;
    assign is_up  = (c >= "A") && (c <= "Z");
    assign is_lo  = (c >= "a") && (c <= "z");
    assign is_dig = (c >= "0") && (c <= "9");
    assign is_aln = is_up || is_lo || is_dig;
    assign lc     = is_up ? c + 8'd32 : c;
    assign eb     = (p > r_pend_start) ? p - 1'b1 : r_pend_start;
    assign fmask  = kw_first_mask(lc);

    always_comb begin
        wmask = '0;
        whit  = 1'b0;
        wkind = K_UNKNOWN;
        for (int k = 0; k < NUM_KW; k++) begin
            if (r_cand[k] && (r_mlen < KW_LEN[k]) && (KW_TEXT[k][r_mlen[2:0]] == lc)) begin
                wmask[k] = 1'b1;
                if (r_mlen + 4'd1 == KW_LEN[k]) begin
                    whit  = 1'b1;
                    wkind = KW_KIND[k];
                end
            end
        end
    end

    // one scan step: at most one token; done=0 rescans the same byte in the new mode
    always_comb begin
        e        = 1'b0;
        ek       = K_UNKNOWN;
        es       = r_pend_start;
        ee       = r_pend_start;
        el       = r_pend_line;
        n_mode   = r_mode;
        n_cand   = r_cand;
        n_mlen   = r_mlen;
        done     = 1'b1;
        set_rep  = 2'd0;
        beg      = 1'b0;
        line_inc = 1'b0;
        restart  = 1'b0;
        unique case (r_mode)
            M_IDLE: begin
                if (eot) begin
                    e       = 1'b1;
                    ek      = K_END;
                    es      = r_cur_pos;
                    ee      = r_cur_pos;
                    el      = r_line;
                    restart = 1'b1;
                end else begin
                    beg = 1'b1;
                    es  = p;
                    ee  = p;
                    el  = r_line;
                    unique case (c)
                        CH_SP, CH_TAB: ;
                        CH_NL: begin
                            e        = !r_skip;
                            ek       = K_NEWLINE;
                            line_inc = 1'b1;
                        end
                        CH_HASH:   n_mode = M_COMMENT;
                        CH_BAR:    n_mode = M_BAR;
                        CH_QUES:   n_mode = M_QUES;
                        CH_BANG:   n_mode = M_BANG;
                        CH_LT:     n_mode = M_LT;
                        CH_DASH:   n_mode = M_MINUS;
                        CH_AMP:    n_mode = M_AMP;
                        CH_QUOTE:  n_mode = M_STRING;
                        CH_TILDE:  begin e = 1'b1; ek = K_NEG;    end
                        CH_EQ:     begin e = 1'b1; ek = K_EQUAL;  end
                        CH_LPAR:   begin e = 1'b1; ek = K_LPAR;   end
                        CH_RPAR:   begin e = 1'b1; ek = K_RPAR;   end
                        CH_COMMA:  begin e = 1'b1; ek = K_COMMA;  end
                        CH_SEMI:   begin e = 1'b1; ek = K_SEMI;   end
                        CH_GT:     begin e = 1'b1; ek = K_RUNIV;  end
                        CH_LBRK:   begin e = 1'b1; ek = K_LEXIST; end
                        CH_RBRK:   begin e = 1'b1; ek = K_REXIST; end
                        CH_LBRACE: begin e = 1'b1; ek = K_LBRACE; end
                        CH_RBRACE: begin e = 1'b1; ek = K_RBRACE; end
                        default: begin
                            if (is_up || is_lo) begin
                                if (fmask != '0) begin
                                    n_cand = fmask;
                                    n_mlen = 4'd1;
                                    n_mode = is_up ? M_WORD_UP : M_WORD_LO;
                                end else begin
                                    n_mode = is_up ? M_PIDENT : M_IDENT;
                                end
                            end else if (is_dig) begin
                                n_mode = M_NUMBER;
                            end else begin
                                e = 1'b1;
                            end
                        end
                    endcase
                end
            end
            M_BAR: begin
                e = 1'b1;
                if (!eot && (c == CH_DASH || c == CH_BAR)) begin
                    ek     = (c == CH_DASH) ? K_THEREFORE : K_OR;
                    ee     = p;
                    n_mode = M_IDLE;
                end else begin
                    n_mode = M_IDLE;
                    done   = 1'b0;
                end
            end
            M_QUES, M_AMP, M_BANG: begin
                e      = 1'b1;
                n_mode = M_IDLE;
                if (!eot && r_mode == M_QUES && c == CH_DASH) begin
                    ek = K_QUERY;
                    ee = p;
                end else if (!eot && r_mode == M_AMP && c == CH_AMP) begin
                    ek = K_AND;
                    ee = p;
                end else if (!eot && r_mode == M_BANG && c == CH_EQ) begin
                    ek = K_NOTEQ;
                    ee = p;
                end else begin
                    ek   = (r_mode == M_BANG) ? K_NEG : K_UNKNOWN;
                    done = 1'b0;
                end
            end
            M_LT, M_LT1: begin
                if (!eot && c == CH_DASH) begin
                    n_mode = (r_mode == M_LT) ? M_LT1 : M_LT2;
                end else begin
                    e       = 1'b1;
                    ek      = K_LUNIV;
                    n_mode  = M_IDLE;
                    done    = 1'b0;
                    set_rep = (r_mode == M_LT1) ? 2'd1 : 2'd0;
                end
            end
            M_LT2: begin
                e      = 1'b1;
                n_mode = M_IDLE;
                if (!eot && c == CH_GT) begin
                    ek = K_BICOND;
                    ee = p;
                end else begin
                    ek      = K_LUNIV;
                    done    = 1'b0;
                    set_rep = 2'd2;
                end
            end
            M_MINUS: begin
                if (!eot && c == CH_DASH) begin
                    n_mode = M_MINUS2;
                end else if (!eot && is_dig) begin
                    n_mode = M_NEGNUM;
                end else begin
                    // dash right before end of text is unknown, otherwise negation
                    e      = 1'b1;
                    ek     = eot ? K_UNKNOWN : K_NEG;
                    n_mode = M_IDLE;
                    done   = 1'b0;
                end
            end
            M_MINUS2: begin
                e      = 1'b1;
                n_mode = M_IDLE;
                if (!eot && c == CH_GT) begin
                    ek = K_IMPL;
                    ee = p;
                end else begin
                    ek      = K_NEG;
                    done    = 1'b0;
                    set_rep = 2'd1;
                end
            end
            M_WORD_LO, M_WORD_UP: begin
                if (eot) begin
                    e      = 1'b1;
                    ek     = (r_mode == M_WORD_UP) ? K_PIDENT : K_IDENT;
                    ee     = eb;
                    n_mode = M_IDLE;
                    done   = 1'b0;
                end else if (whit) begin
                    e      = 1'b1;
                    ek     = wkind;
                    ee     = p;
                    n_mode = M_IDLE;
                end else if (wmask != '0) begin
                    n_cand = wmask;
                    n_mlen = r_mlen + 4'd1;
                end else begin
                    n_mode = (r_mode == M_WORD_UP) ? M_PIDENT : M_IDENT;
                    done   = 1'b0;
                end
            end
            M_IDENT, M_PIDENT: begin
                if (eot || !is_aln) begin
                    e      = 1'b1;
                    ek     = (r_mode == M_PIDENT) ? K_PIDENT : K_IDENT;
                    ee     = eb;
                    n_mode = M_IDLE;
                    done   = 1'b0;
                end
            end
            M_NUMBER, M_NEGNUM: begin
                if (eot || !is_dig) begin
                    e      = 1'b1;
                    ek     = (r_mode == M_NEGNUM) ? K_NEGNUM : K_NUMBER;
                    ee     = eb;
                    n_mode = M_IDLE;
                    done   = 1'b0;
                end
            end
            M_STRING: begin
                if (eot) begin
                    n_mode = M_IDLE;
                    done   = 1'b0;
                end else if (c == CH_QUOTE) begin
                    e      = 1'b1;
                    ek     = K_STRING;
                    ee     = p;
                    n_mode = M_IDLE;
                end
            end
            M_COMMENT: begin
                if (eot || c == CH_NL) begin
                    line_inc = 1'b1;
                    n_mode   = M_IDLE;
                    done     = eot ? 1'b0 : 1'b1;
                end
            end
            default: begin
                n_mode = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip       <= 1'b0;
            r_mode       <= M_IDLE;
            r_cand       <= '0;
            r_mlen       <= '0;
            r_cur_pos    <= '0;
            r_pend_start <= '0;
            r_line       <= t_line'(1);
            r_pend_line  <= t_line'(1);
            r_rep_cnt    <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_skip <= i_cfg_wr_data;
            end
            if (i_cmd.load) begin
                if (!i_end_of_text) begin
                    r_cur_pos <= (r_cur_pos == '1) ? r_cur_pos : r_cur_pos + 1'b1;
                end
            end
            if (i_cmd.step) begin
                r_mode <= n_mode;
                r_cand <= n_cand;
                r_mlen <= n_mlen;
                if (beg) begin
                    r_pend_start <= p;
                    r_pend_line  <= r_line;
                end
                if (line_inc) begin
                    r_line <= (r_line == '1) ? r_line : r_line + 1'b1;
                end
                if (done && rep) begin
                    r_rep_cnt <= r_rep_cnt - 2'd1;
                    r_rep_pos <= (r_rep_pos == '1) ? r_rep_pos : r_rep_pos + 1'b1;
                end else if (set_rep != 2'd0) begin
                    r_rep_cnt <= set_rep;
                    r_rep_pos <= (r_pend_start == '1) ? r_pend_start : r_pend_start + 1'b1;
                end
                if (restart) begin
                    r_mode       <= M_IDLE;
                    r_cand       <= '0;
                    r_mlen       <= '0;
                    r_cur_pos    <= '0;
                    r_pend_start <= '0;
                    r_line       <= t_line'(1);
                    r_pend_line  <= t_line'(1);
                end
            end
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.step && e) begin
                r_hold_valid <= 1'b1;
                if (r_hold_valid) begin
                    r_out_valid <= 1'b1;
                end
            end else if (i_cmd.push_last) begin
                r_hold_valid <= 1'b0;
                r_out_valid  <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_text_byte;
            r_eot  <= i_end_of_text;
            r_pos  <= r_cur_pos;
        end
        if (i_cmd.step && e) begin
            r_hold_kind  <= ek;
            r_hold_start <= es;
            r_hold_end   <= ee;
            r_hold_line  <= el;
        end
        if ((i_cmd.step && e && r_hold_valid) || i_cmd.push_last) begin
            r_out_kind  <= r_hold_kind;
            r_out_start <= r_hold_start;
            r_out_end   <= r_hold_end;
            r_out_line  <= r_hold_line;
            r_out_last  <= i_cmd.push_last;
        end
    end

    assign o_stat.emit       = e;
    assign o_stat.item_done  = done && !rep;
    assign o_stat.hold_valid = r_hold_valid;
    assign o_stat.out_valid  = r_out_valid;

    assign o_out_valid   = r_out_valid;
    assign o_token_kind  = r_out_kind;
    assign o_token_start = r_out_start;
    assign o_token_end   = r_out_end;
    assign o_line_number = r_out_line;
    assign o_last_of_run = r_out_last;

endmodule

// ----- rtl/predicate_logic_lexer_top.sv -----
// ----------------------------------------------------------------------------
// Predicate logic lexer
// Byte-at-a-time tokenizer for predicate calculus program text.
// ----------------------------------------------------------------------------
// Each item is one text byte or an end-of-text mark. An item passes through
// intake, one or more scan steps and release of its last token: a token that
// closes before the byte is rescanned, and each dash replayed after a failed
// "<-", "<--" or "--" adds a scan step. The single scan step unit produces at
// most one token per cycle and waits while the token output is stalled.
// Up to four tokens come from one item, the last flagged by last_of_run.
module predicate_logic_lexer_top
    import plx_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int LINE_BITS     = LINE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_wr_data,
    plx_byte_if.sink         i_text,
    plx_tok_if.source        o_tok
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    plx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_text.valid),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_tok.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    plx_dpath #(
        .POSITION_BITS (POSITION_BITS),
        .LINE_BITS     (LINE_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_text_byte   (i_text.text_byte),
        .i_end_of_text (i_text.end_of_text),
        .i_out_ready   (o_tok.ready),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_out_valid   (o_tok.valid),
        .o_token_kind  (o_tok.token_kind),
        .o_token_start (o_tok.token_start),
        .o_token_end   (o_tok.token_end),
        .o_line_number (o_tok.line_number),
        .o_last_of_run (o_tok.last_of_run)
    );

    assign i_text.ready = w_in_ready;

endmodule

// ----- tb/sv/tb_predicate_logic_lexer_top.sv -----
// ----------------------------------------------------------------------------
// Predicate logic lexer testbench
// Feeds text bytes and end-of-text marks through the byte channel and checks
// every token against an in-bench lexer model. Runs with a short directed
// table, then random token-shaped text, under three idle/stall profiles and
// both newline settings.
// ----------------------------------------------------------------------------
module tb_predicate_logic_lexer_top
    import plx_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [23:0] POS_SAT  = 24'hFFFFFF;
    localparam logic [23:0] LINE_SAT = 24'hFFFFFF;
    localparam int          MAX_TOK  = 4;
    localparam int          SETTLE   = 20;

    typedef enum logic [4:0] {
        SM_IDLE, SM_BAR, SM_QUES, SM_BANG, SM_LT, SM_LT1, SM_LT2, SM_MINUS, SM_MINUS2,
        SM_AMP, SM_WORD_LO, SM_WORD_UP, SM_IDENT, SM_PIDENT, SM_NUMBER, SM_NEGNUM,
        SM_STRING, SM_COMMENT
    } scan_mode_e;

    typedef struct packed {
        t_kind       kind;
        logic [23:0] first;
        logic [23:0] last;
        logic [23:0] line;
        logic        run_end;
    } token_t;

    typedef struct {
        logic [7:0] ch;
        logic       eot;
        logic       typed;
        t_kind      kind;
    } text_row_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic i_cfg_wr_data;

    plx_byte_if text_if ();
    plx_tok_if  tok_if ();

    predicate_logic_lexer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_text        (text_if),
        .o_tok         (tok_if)
    );

    // lexer model state
    logic        skip_nl;
    scan_mode_e  mode;
    logic [7:0]  kw_cand;
    logic [3:0]  kw_len_seen;
    logic [23:0] cur_pos;
    logic [23:0] tok_first;
    logic [23:0] line_cnt;
    logic [23:0] tok_line;

    string kw_word [8] = '{"quit", "true", "false", "argument",
                           "forall", "forsome", "sos", "options"};
    t_kind kw_tok  [8] = '{K_QUIT, K_TRUE, K_FALSE, K_ARGUMENT,
                           K_FORALL, K_FORSOME, K_SOS, K_OPTIONS};

    token_t item_toks [$];
    token_t expected_toks [$];

    int errors;
    int src_idle;
    int snk_idle;
    logic snk_hold;
    int items_sent;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #2000000;
        $display("tb_predicate_logic_lexer_top: FAIL");
        $finish;
    end

    function automatic logic [23:0] pos_inc(logic [23:0] v);
        return (v < POS_SAT) ? v + 24'd1 : POS_SAT;
    endfunction

    function automatic logic [23:0] line_inc(logic [23:0] v);
        return (v < LINE_SAT) ? v + 24'd1 : LINE_SAT;
    endfunction

    function automatic bit is_lo(logic [7:0] c);
        return c >= "a" && c <= "z";
    endfunction

    function automatic bit is_up(logic [7:0] c);
        return c >= "A" && c <= "Z";
    endfunction

    function automatic bit is_dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void tok_push(t_kind k, logic [23:0] s, logic [23:0] e,
                                     logic [23:0] l);
        token_t t;
        if (item_toks.size() >= MAX_TOK) return;
        t.kind    = k;
        t.first   = s;
        t.last    = (e < s) ? s : e;
        t.line    = l;
        t.run_end = 1'b0;
        item_toks.push_back(t);
    endfunction

    function automatic void tok_one(t_kind k);
        tok_push(k, tok_first, tok_first, tok_line);
    endfunction

    function automatic logic [23:0] end_at(logic [23:0] pos);
        return (pos > tok_first) ? pos - 24'd1 : tok_first;
    endfunction

    function automatic void lex_start(logic [7:0] c, logic [23:0] pos);
        logic [7:0] cand;
        logic [7:0] lc;
        cand      = '0;
        tok_first = pos;
        tok_line  = line_cnt;
        mode      = SM_IDLE;
        case (c)
            CH_SP, CH_TAB: ;
            CH_NL: begin
                if (!skip_nl) tok_one(K_NEWLINE);
                line_cnt = line_inc(line_cnt);
            end
            CH_HASH:   mode = SM_COMMENT;
            CH_BAR:    mode = SM_BAR;
            CH_QUES:   mode = SM_QUES;
            CH_BANG:   mode = SM_BANG;
            CH_LT:     mode = SM_LT;
            CH_DASH:   mode = SM_MINUS;
            CH_AMP:    mode = SM_AMP;
            CH_QUOTE:  mode = SM_STRING;
            CH_TILDE:  tok_one(K_NEG);
            CH_EQ:     tok_one(K_EQUAL);
            CH_LPAR:   tok_one(K_LPAR);
            CH_RPAR:   tok_one(K_RPAR);
            CH_COMMA:  tok_one(K_COMMA);
            CH_SEMI:   tok_one(K_SEMI);
            CH_GT:     tok_one(K_RUNIV);
            CH_LBRK:   tok_one(K_LEXIST);
            CH_RBRK:   tok_one(K_REXIST);
            CH_LBRACE: tok_one(K_LBRACE);
            CH_RBRACE: tok_one(K_RBRACE);
            default: begin
                if (is_lo(c) || is_up(c)) begin
                    lc = is_up(c) ? c + 8'd32 : c;
                    for (int k = 0; k < 8; k++) cand[k] = (kw_word[k][0] == lc);
                    if (cand != 0) begin
                        kw_cand     = cand;
                        kw_len_seen = 4'd1;
                        mode        = is_up(c) ? SM_WORD_UP : SM_WORD_LO;
                    end else begin
                        mode = is_up(c) ? SM_PIDENT : SM_IDENT;
                    end
                end else if (is_dig(c)) begin
                    mode = SM_NUMBER;
                end else begin
                    tok_one(K_UNKNOWN);
                end
            end
        endcase
    endfunction

    // one-byte token at the pending start, then rescan dashes and the byte
    function automatic void lex_retry(t_kind k, int dashes, logic [7:0] c,
                                      logic [23:0] pos);
        logic [23:0] p;
        p = tok_first;
        tok_one(k);
        mode = SM_IDLE;
        for (int i = 0; i < dashes; i++) begin
            p = pos_inc(p);
            lex_scan(CH_DASH, p);
        end
        lex_scan(c, pos);
    endfunction

    function automatic void lex_word(logic [7:0] c, logic [23:0] pos);
        logic [7:0] lc;
        logic [7:0] mask;
        int hit;
        lc   = is_up(c) ? c + 8'd32 : c;
        mask = '0;
        hit  = -1;
        for (int k = 0; k < 8; k++) begin
            if (kw_cand[k] && kw_len_seen < kw_word[k].len() &&
                kw_word[k][kw_len_seen] == lc) begin
                mask[k] = 1'b1;
                if (kw_len_seen + 1 == kw_word[k].len()) hit = k;
            end
        end
        if (hit >= 0) begin
            tok_push(kw_tok[hit], tok_first, pos, tok_line);
            mode = SM_IDLE;
        end else if (mask != 0) begin
            kw_cand     = mask;
            kw_len_seen = kw_len_seen + 4'd1;
        end else begin
            mode = (mode == SM_WORD_UP) ? SM_PIDENT : SM_IDENT;
            lex_scan(c, pos);
        end
    endfunction

    function automatic void lex_scan(logic [7:0] c, logic [23:0] pos);
        case (mode)
            SM_BAR: begin
                if (c == CH_DASH) begin
                    tok_push(K_THEREFORE, tok_first, pos, tok_line);
                    mode = SM_IDLE;
                end else if (c == CH_BAR) begin
                    tok_push(K_OR, tok_first, pos, tok_line);
                    mode = SM_IDLE;
                end else lex_retry(K_UNKNOWN, 0, c, pos);
            end
            SM_QUES: begin
                if (c == CH_DASH) begin
                    tok_push(K_QUERY, tok_first, pos, tok_line);
                    mode = SM_IDLE;
                end else lex_retry(K_UNKNOWN, 0, c, pos);
            end
            SM_BANG: begin
                if (c == CH_EQ) begin
                    tok_push(K_NOTEQ, tok_first, pos, tok_line);
                    mode = SM_IDLE;
                end else lex_retry(K_NEG, 0, c, pos);
            end
            SM_AMP: begin
                if (c == CH_AMP) begin
                    tok_push(K_AND, tok_first, pos, tok_line);
                    mode = SM_IDLE;
                end else lex_retry(K_UNKNOWN, 0, c, pos);
            end
            SM_LT: begin
                if (c == CH_DASH) mode = SM_LT1;
                else lex_retry(K_LUNIV, 0, c, pos);
            end
            SM_LT1: begin
                if (c == CH_DASH) mode = SM_LT2;
                else lex_retry(K_LUNIV, 1, c, pos);
            end
            SM_LT2: begin
                if (c == CH_GT) begin
                    tok_push(K_BICOND, tok_first, pos, tok_line);
                    mode = SM_IDLE;
                end else lex_retry(K_LUNIV, 2, c, pos);
            end
            SM_MINUS: begin
                if (c == CH_DASH) mode = SM_MINUS2;
                else if (is_dig(c)) mode = SM_NEGNUM;
                else lex_retry(K_NEG, 0, c, pos);
            end
            SM_MINUS2: begin
                if (c == CH_GT) begin
                    tok_push(K_IMPL, tok_first, pos, tok_line);
                    mode = SM_IDLE;
                end else lex_retry(K_NEG, 1, c, pos);
            end
            SM_WORD_LO, SM_WORD_UP: lex_word(c, pos);
            SM_IDENT, SM_PIDENT: begin
                if (!(is_lo(c) || is_up(c) || is_dig(c))) begin
                    tok_push(mode == SM_IDENT ? K_IDENT : K_PIDENT, tok_first,
                             end_at(pos), tok_line);
                    mode = SM_IDLE;
                    lex_scan(c, pos);
                end
            end
            SM_NUMBER, SM_NEGNUM: begin
                if (!is_dig(c)) begin
                    tok_push(mode == SM_NUMBER ? K_NUMBER : K_NEGNUM, tok_first,
                             end_at(pos), tok_line);
                    mode = SM_IDLE;
                    lex_scan(c, pos);
                end
            end
            SM_STRING: begin
                if (c == CH_QUOTE) begin
                    tok_push(K_STRING, tok_first, pos, tok_line);
                    mode = SM_IDLE;
                end
            end
            SM_COMMENT: begin
                if (c == CH_NL) begin
                    line_cnt = line_inc(line_cnt);
                    mode     = SM_IDLE;
                end
            end
            default: lex_start(c, pos);
        endcase
    endfunction

    // close whatever token is open at end of text
    function automatic void lex_flush();
        logic [23:0] p;
        scan_mode_e m;
        p    = tok_first;
        m    = mode;
        mode = SM_IDLE;
        case (m)
            SM_BAR, SM_QUES, SM_AMP, SM_MINUS: tok_one(K_UNKNOWN);
            SM_BANG: tok_one(K_NEG);
            SM_LT:   tok_one(K_LUNIV);
            SM_LT1: begin
                tok_one(K_LUNIV);
                lex_scan(CH_DASH, pos_inc(p));
                lex_flush();
            end
            SM_LT2: begin
                tok_one(K_LUNIV);
                lex_scan(CH_DASH, pos_inc(p));
                lex_scan(CH_DASH, pos_inc(pos_inc(p)));
                lex_flush();
            end
            SM_MINUS2: begin
                tok_one(K_NEG);
                lex_scan(CH_DASH, pos_inc(p));
                lex_flush();
            end
            SM_WORD_LO, SM_IDENT:  tok_push(K_IDENT, p, end_at(cur_pos), tok_line);
            SM_WORD_UP, SM_PIDENT: tok_push(K_PIDENT, p, end_at(cur_pos), tok_line);
            SM_NUMBER: tok_push(K_NUMBER, p, end_at(cur_pos), tok_line);
            SM_NEGNUM: tok_push(K_NEGNUM, p, end_at(cur_pos), tok_line);
            SM_COMMENT: line_cnt = line_inc(line_cnt);
            default: ;
        endcase
    endfunction

    function automatic void lex_restart();
        mode        = SM_IDLE;
        kw_cand     = '0;
        kw_len_seen = '0;
        cur_pos     = '0;
        tok_first   = '0;
        line_cnt    = 24'd1;
        tok_line    = 24'd1;
    endfunction

    function automatic void lex_item(logic [7:0] c, logic eot);
        logic [23:0] pos;
        item_toks.delete();
        if (eot) begin
            lex_flush();
            tok_push(K_END, cur_pos, cur_pos, line_cnt);
            lex_restart();
        end else begin
            pos     = cur_pos;
            cur_pos = pos_inc(cur_pos);
            lex_scan(c, pos);
        end
        if (item_toks.size() > 0) item_toks[item_toks.size()-1].run_end = 1'b1;
        foreach (item_toks[i]) expected_toks.push_back(item_toks[i]);
    endfunction

    task automatic send_item(logic [7:0] c, logic eot);
        if ($urandom_range(99) < src_idle) begin
            text_if.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < src_idle) @(posedge i_clk);
        end
        text_if.valid       <= 1'b1;
        text_if.text_byte   <= c;
        text_if.end_of_text <= eot;
        do @(posedge i_clk); while (!text_if.ready);
        lex_item(c, eot);
        items_sent++;
    endtask

    task automatic wait_drained();
        text_if.valid <= 1'b0;
        while (expected_toks.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_skip_nl(logic v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        skip_nl = v;
    endtask

    function automatic void add_text(ref logic [7:0] q [$], input string s);
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    endfunction

    function automatic void add_word(ref logic [7:0] q [$], input logic upper_first);
        int n;
        n = $urandom_range(1, 5);
        q.push_back(upper_first ? 8'($urandom_range("A", "Z")) : 8'($urandom_range("a", "z")));
        for (int i = 1; i < n; i++) begin
            case ($urandom_range(2))
                0: q.push_back(8'($urandom_range("a", "z")));
                1: q.push_back(8'($urandom_range("A", "Z")));
                default: q.push_back(8'($urandom_range("0", "9")));
            endcase
        end
    endfunction

    // random token-shaped text with a little noise
    function automatic void make_fragment(ref logic [7:0] q [$]);
        string ops [16] = '{"|-", "||", "?-", "!=", "!", "~", "=", "-->", "<-->", "<",
                            "&&", "(", ")", ",", ";", ">"};
        string bad [8]  = '{"|", "?", "&", "<-", "<--", "--", "-", "<-x"};
        string pun [4]  = '{"[", "]", "{", "}"};
        string w;
        int n;
        case ($urandom_range(15))
            0, 1: add_text(q, ops[$urandom_range(15)]);
            2: add_text(q, pun[$urandom_range(3)]);
            3, 4: begin
                w = kw_word[$urandom_range(7)];
                for (int i = 0; i < w.len(); i++)
                    q.push_back($urandom_range(1) ? w[i] - 8'd32 : w[i]);
            end
            5: add_word(q, 1'b0);
            6: add_word(q, 1'b1);
            7, 8: begin
                if ($urandom_range(1)) q.push_back(CH_DASH);
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) q.push_back(8'($urandom_range("0", "9")));
            end
            9: begin
                q.push_back(CH_QUOTE);
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++)
                    q.push_back($urandom_range(5) == 0 ? CH_NL : 8'($urandom_range("a", "z")));
                q.push_back(CH_QUOTE);
            end
            10: begin
                q.push_back(CH_HASH);
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(32, 126)));
                q.push_back(CH_NL);
            end
            11: q.push_back(CH_NL);
            12: q.push_back($urandom_range(1) ? CH_SP : CH_TAB);
            13: add_text(q, bad[$urandom_range(7)]);
            default: q.push_back(8'($urandom_range(255)));
        endcase
        if ($urandom_range(2) == 0) q.push_back(CH_SP);
    endfunction

    task automatic random_text(int count);
        logic [7:0] frag [$];
        int target;
        target = items_sent + count;
        while (items_sent < target) begin
            frag.delete();
            if ($urandom_range(29) == 0) begin
                send_item(8'($urandom_range(255)), 1'b1);
            end else begin
                make_fragment(frag);
                foreach (frag[i]) send_item(frag[i], 1'b0);
            end
        end
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    // token checker and receiver stalls
    always @(posedge i_clk) begin
        token_t exp_tok;
        if (i_rst_n && tok_if.valid && tok_if.ready) begin
            if (expected_toks.size() == 0) begin
                $error("unexpected token kind %0d", tok_if.token_kind);
                errors++;
            end else begin
                exp_tok = expected_toks.pop_front();
                if (tok_if.token_kind !== exp_tok.kind) begin
                    $error("token_kind exp %0d got %0d", exp_tok.kind, tok_if.token_kind);
                    errors++;
                end
                if (tok_if.token_start !== exp_tok.first) begin
                    $error("token_start exp %0d got %0d", exp_tok.first, tok_if.token_start);
                    errors++;
                end
                if (tok_if.token_end !== exp_tok.last) begin
                    $error("token_end exp %0d got %0d", exp_tok.last, tok_if.token_end);
                    errors++;
                end
                if (tok_if.line_number !== exp_tok.line) begin
                    $error("line_number exp %0d got %0d", exp_tok.line, tok_if.line_number);
                    errors++;
                end
                if (tok_if.last_of_run !== exp_tok.run_end) begin
                    $error("last_of_run exp %0d got %0d", exp_tok.run_end,
                           tok_if.last_of_run);
                    errors++;
                end
            end
        end
        tok_if.ready <= !snk_hold && ($urandom_range(99) >= snk_idle);
    end

    // long receiver hold-off so the lexer backs up into its input
    initial begin
        snk_hold = 1'b0;
        wait (items_sent >= 60);
        @(posedge i_clk);
        snk_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        snk_hold <= 1'b0;
    end

    initial begin
        text_row_t rows [$] = '{
            '{8'h00, 1'b1, 1'b1, K_END},
            '{8'hFF, 1'b0, 1'b1, K_UNKNOWN},
            '{8'h00, 1'b0, 1'b1, K_UNKNOWN},
            '{CH_TILDE, 1'b0, 1'b1, K_NEG},
            '{CH_LT, 1'b0, 1'b0, K_UNKNOWN},
            '{CH_DASH, 1'b0, 1'b0, K_UNKNOWN},
            '{CH_DASH, 1'b0, 1'b0, K_UNKNOWN},
            '{"x", 1'b0, 1'b1, K_LUNIV},
            '{CH_DASH, 1'b0, 1'b0, K_UNKNOWN},
            '{CH_DASH, 1'b0, 1'b0, K_UNKNOWN},
            '{CH_GT, 1'b0, 1'b0, K_UNKNOWN},
            '{CH_BAR, 1'b0, 1'b0, K_UNKNOWN},
            '{"Q", 1'b0, 1'b1, K_UNKNOWN},
            '{"U", 1'b0, 1'b0, K_UNKNOWN},
            '{"i", 1'b0, 1'b0, K_UNKNOWN},
            '{"t", 1'b0, 1'b1, K_QUIT},
            '{"9", 1'b0, 1'b0, K_UNKNOWN},
            '{CH_NL, 1'b0, 1'b1, K_NUMBER},
            '{CH_HASH, 1'b0, 1'b0, K_UNKNOWN},
            '{"a", 1'b0, 1'b0, K_UNKNOWN},
            '{CH_DASH, 1'b1, 1'b1, K_END},
            '{CH_QUOTE, 1'b0, 1'b0, K_UNKNOWN},
            '{CH_LT, 1'b1, 1'b1, K_END},
            '{CH_DASH, 1'b0, 1'b0, K_UNKNOWN},
            '{8'h7F, 1'b1, 1'b1, K_UNKNOWN}
        };

        errors              = 0;
        items_sent          = 0;
        src_idle            = 21;
        snk_idle            = 78;
        i_rst_n             = 1'b0;
        i_cfg_wr_en         = 1'b0;
        i_cfg_wr_data       = 1'b0;
        text_if.valid       = 1'b0;
        text_if.text_byte   = 8'h00;
        text_if.end_of_text = 1'b0;
        tok_if.ready        = 1'b0;
        skip_nl             = 1'b0;
        lex_restart();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_skip_nl(1'b0);
        foreach (rows[r]) begin
            send_item(rows[r].ch, rows[r].eot);
            // first token of the item, as produced for this row
            if (rows[r].typed) begin
                if (item_toks.size() == 0) begin
                    $error("token_kind exp %0d got none", rows[r].kind);
                    errors++;
                end else if (item_toks[0].kind != rows[r].kind) begin
                    $error("token_kind exp %0d got %0d", rows[r].kind, item_toks[0].kind);
                    errors++;
                end
            end
        end
        random_text(100);
        wait_drained();

        src_idle = 78;
        snk_idle = 21;
        write_skip_nl(1'b1);
        random_text(130);
        wait_drained();

        src_idle = 0;
        snk_idle = 0;
        write_skip_nl(1'b0);
        random_text(130);
        wait_drained();

        if (errors == 0) begin
            $display("tb_predicate_logic_lexer_top: PASS");
        end else begin
            $display("tb_predicate_logic_lexer_top: FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/plx_pkg.sv
rtl/plx_byte_if.sv
rtl/plx_tok_if.sv
rtl/plx_ctrl.sv
rtl/plx_dpath.sv
rtl/predicate_logic_lexer_top.sv
tb/sv/tb_predicate_logic_lexer_top.sv
